### design/lwc_pkg.sv
`default_nettype none

package lwc_pkg;

   localparam int FIELD_W   = 16;
   localparam int CORR_W    = 16;
   localparam int ONE_Q14   = 16384;
   localparam int SCALE_SH  = 30;
   localparam int QUO_W     = 31;
   localparam int ROOT_W    = 16;

   typedef struct packed {
      logic busy;
      logic done;
   } lwc_status_type;

endpackage

`default_nettype wire

### design/lwc_front.sv
`default_nettype none

module lwc_front #(
   parameter int WINDOW_LEN  = 16,
   parameter int LAG_LEN     = 64,
   parameter int SAMPLE_BITS = 16,
   parameter int EW          = 44
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [lwc_pkg::FIELD_W-1:0]       req_sample_re,
   input  wire logic [lwc_pkg::FIELD_W-1:0]       req_sample_im,
   output logic                                   push,
   input  wire logic                              full,
   output logic [6*EW-1:0]                        wdata
);

   localparam int SB     = SAMPLE_BITS;
   localparam int HIST   = LAG_LEN + WINDOW_LEN;
   localparam int LW     = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W  = SB + LW;
   localparam int PRD_W  = 2 * SB;
   localparam int SQS_W  = 2 * SB + LW;
   localparam int FILL_W = $clog2(HIST + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PROD = 3'd1;
   localparam logic [2:0] S_ACC  = 3'd2;
   localparam logic [2:0] S_NORM = 3'd3;
   localparam logic [2:0] S_PUSH = 3'd4;

   logic [2:0]              state_ff;
   logic [FILL_W-1:0]       fill_ff;
   logic signed [SB-1:0]    hist_re_ff [0:HIST-1];
   logic signed [SB-1:0]    hist_im_ff [0:HIST-1];
   logic signed [SB-1:0]    new_re_ff, new_im_ff;

   // product order: new^2, leave^2, lag^2, old^2, lag*new, old*leave
   logic signed [PRD_W-1:0] pr_ff [0:5];
   logic signed [PRD_W-1:0] pi_ff [0:5];

   logic signed [SUM_W-1:0] re_se_ff, re_sl_ff, im_se_ff, im_sl_ff;
   logic signed [SQS_W-1:0] re_qe_ff, re_ql_ff, re_sx_ff, im_qe_ff, im_ql_ff, im_sx_ff;
   logic signed [EW-1:0]    re_n_ff, re_da_ff, re_db_ff, im_n_ff, im_da_ff, im_db_ff;

   logic [SB+lwc_pkg::FIELD_W-1:0] ext_re, ext_im;
   logic signed [SB-1:0]    lag_re, lag_im, leave_re, leave_im, old_re, old_im;
   logic signed [EW-1:0]    re_n_in, re_da_in, re_db_in, im_n_in, im_da_in, im_db_in;

   always_comb begin
      ext_re   = {{SB{1'b0}}, req_sample_re};
      ext_im   = {{SB{1'b0}}, req_sample_im};
      lag_re   = hist_re_ff[LAG_LEN-1];
      lag_im   = hist_im_ff[LAG_LEN-1];
      leave_re = hist_re_ff[WINDOW_LEN-1];
      leave_im = hist_im_ff[WINDOW_LEN-1];
      old_re   = hist_re_ff[HIST-1];
      old_im   = hist_im_ff[HIST-1];
   end

   function automatic logic signed [EW-1:0] norm_term(
      input logic signed [SQS_W-1:0] q,
      input logic signed [SUM_W-1:0] a,
      input logic signed [SUM_W-1:0] b
   );
      logic signed [2*SUM_W-1:0] ab;
      logic signed [EW-1:0]      wq;
      ab = a * b;
      wq = EW'(q) * EW'(WINDOW_LEN);
      return wq - EW'(ab);
   endfunction

   always_comb begin
      re_n_in  = norm_term(re_sx_ff, re_se_ff, re_sl_ff);
      re_da_in = norm_term(re_qe_ff, re_se_ff, re_se_ff);
      re_db_in = norm_term(re_ql_ff, re_sl_ff, re_sl_ff);
      im_n_in  = norm_term(im_sx_ff, im_se_ff, im_sl_ff);
      im_da_in = norm_term(im_qe_ff, im_se_ff, im_se_ff);
      im_db_in = norm_term(im_ql_ff, im_sl_ff, im_sl_ff);
   end

   assign req_stall = (state_ff != S_IDLE);
   assign push      = (state_ff == S_PUSH) && !full;
   assign wdata     = {re_n_ff, re_da_ff, re_db_ff, im_n_ff, im_da_ff, im_db_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         re_se_ff <= '0;
         re_sl_ff <= '0;
         im_se_ff <= '0;
         im_sl_ff <= '0;
         re_qe_ff <= '0;
         re_ql_ff <= '0;
         re_sx_ff <= '0;
         im_qe_ff <= '0;
         im_ql_ff <= '0;
         im_sx_ff <= '0;
         for (int i = 0; i < HIST; i++) begin
            hist_re_ff[i] <= '0;
            hist_im_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  new_re_ff <= ext_re[SB-1:0];
                  new_im_ff <= ext_im[SB-1:0];
                  state_ff  <= S_PROD;
               end
            end
            S_PROD: begin
               pr_ff[0] <= new_re_ff * new_re_ff;
               pr_ff[1] <= leave_re * leave_re;
               pr_ff[2] <= lag_re * lag_re;
               pr_ff[3] <= old_re * old_re;
               pr_ff[4] <= lag_re * new_re_ff;
               pr_ff[5] <= old_re * leave_re;
               pi_ff[0] <= new_im_ff * new_im_ff;
               pi_ff[1] <= leave_im * leave_im;
               pi_ff[2] <= lag_im * lag_im;
               pi_ff[3] <= old_im * old_im;
               pi_ff[4] <= lag_im * new_im_ff;
               pi_ff[5] <= old_im * leave_im;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               re_sl_ff <= re_sl_ff + SUM_W'(new_re_ff) - SUM_W'(leave_re);
               re_se_ff <= re_se_ff + SUM_W'(lag_re) - SUM_W'(old_re);
               re_ql_ff <= re_ql_ff + SQS_W'(pr_ff[0]) - SQS_W'(pr_ff[1]);
               re_qe_ff <= re_qe_ff + SQS_W'(pr_ff[2]) - SQS_W'(pr_ff[3]);
               re_sx_ff <= re_sx_ff + SQS_W'(pr_ff[4]) - SQS_W'(pr_ff[5]);
               im_sl_ff <= im_sl_ff + SUM_W'(new_im_ff) - SUM_W'(leave_im);
               im_se_ff <= im_se_ff + SUM_W'(lag_im) - SUM_W'(old_im);
               im_ql_ff <= im_ql_ff + SQS_W'(pi_ff[0]) - SQS_W'(pi_ff[1]);
               im_qe_ff <= im_qe_ff + SQS_W'(pi_ff[2]) - SQS_W'(pi_ff[3]);
               im_sx_ff <= im_sx_ff + SQS_W'(pi_ff[4]) - SQS_W'(pi_ff[5]);
               hist_re_ff[0] <= new_re_ff;
               hist_im_ff[0] <= new_im_ff;
               for (int i = 1; i < HIST; i++) begin
                  hist_re_ff[i] <= hist_re_ff[i-1];
                  hist_im_ff[i] <= hist_im_ff[i-1];
               end
               if (fill_ff < FILL_W'(HIST)) begin
                  fill_ff <= fill_ff + 1'b1;
               end
               if (fill_ff >= FILL_W'(HIST - 1)) begin
                  state_ff <= S_NORM;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_NORM: begin
               re_n_ff  <= re_n_in;
               re_da_ff <= re_da_in;
               re_db_ff <= re_db_in;
               im_n_ff  <= im_n_in;
               im_da_ff <= im_da_in;
               im_db_ff <= im_db_in;
               state_ff <= S_PUSH;
            end
            S_PUSH: begin
               if (!full) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### design/lwc_queue.sv
`default_nettype none

module lwc_queue #(
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      rdata,
   output logic                   full,
   output logic                   empty
);

   logic [DATA_W-1:0] mem_ff [0:1];
   logic              wptr_ff, rptr_ff;
   logic [1:0]        count_ff;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign rdata = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (pop) begin
            rptr_ff <= ~rptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

### design/lwc_ratio.sv
`default_nettype none

module lwc_ratio #(
   parameter int EW = 44
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          ack,
   input  wire logic signed [EW-1:0]          num,
   input  wire logic signed [EW-1:0]          da,
   input  wire logic signed [EW-1:0]          db,
   output lwc_pkg::lwc_status_type            status,
   output logic [lwc_pkg::CORR_W-1:0]         corr,
   output logic                               degen
);

   localparam int MW = 2 * EW;
   localparam int QW = lwc_pkg::QUO_W;
   localparam int RW = MW + QW;
   localparam int RT = lwc_pkg::ROOT_W;
   localparam int CW = $clog2(EW + QW + 1);

   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_SQ   = 3'd1;
   localparam logic [2:0] P_PROD = 3'd2;
   localparam logic [2:0] P_DIV  = 3'd3;
   localparam logic [2:0] P_ROOT = 3'd4;
   localparam logic [2:0] P_DONE = 3'd5;

   logic [2:0]    phase_ff;
   logic [CW-1:0] cnt_ff;
   logic [MW-1:0] mcand_ff, acc_ff, sq_ff;
   logic [EW-1:0] mplier_ff, db_ff;
   logic [RW-1:0] rem_ff, dvs_ff;
   logic [QW-1:0] quo_ff;
   logic [RT-1:0] root_ff;
   logic          neg_ff, degen_ff;

   logic [MW-1:0]   acc_in;
   logic [RT-1:0]   trial;
   logic [2*RT-1:0] trial_sq;
   logic [RT:0]     half;
   logic [RT-1:0]   mag_q;
   logic            degen_in;
   logic [EW-1:0]   mag_in;

   always_comb begin
      acc_in   = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
      trial    = root_ff | (RT'(1) << cnt_ff[$clog2(RT)-1:0]);
      trial_sq = trial * trial;
      half     = ({1'b0, root_ff} + 1'b1) >> 1;
      mag_q    = (half > (RT+1)'(lwc_pkg::ONE_Q14)) ? RT'(lwc_pkg::ONE_Q14) : half[RT-1:0];
      degen_in = (da <= 0) || (db <= 0);
      mag_in   = num[EW-1] ? EW'(-num) : EW'(num);
   end

   assign status.busy = (phase_ff != P_IDLE);
   assign status.done = (phase_ff == P_DONE);
   assign degen       = degen_ff;
   assign corr        = degen_ff ? '0 : (neg_ff ? lwc_pkg::CORR_W'(-mag_q) : mag_q);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
      end else begin
         case (phase_ff)
            P_IDLE: begin
               if (start) begin
                  degen_ff  <= degen_in;
                  neg_ff    <= num[EW-1];
                  mcand_ff  <= MW'(mag_in);
                  mplier_ff <= mag_in;
                  db_ff     <= degen_in ? EW'(1) : db;
                  sq_ff     <= degen_in ? MW'(1) : MW'(da);
                  acc_ff    <= '0;
                  cnt_ff    <= CW'(EW - 1);
                  phase_ff  <= P_SQ;
               end
            end
            P_SQ: begin
               mcand_ff  <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
               acc_ff    <= acc_in;
               cnt_ff    <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  mcand_ff  <= sq_ff;
                  mplier_ff <= db_ff;
                  sq_ff     <= acc_in;
                  acc_ff    <= '0;
                  cnt_ff    <= CW'(EW - 1);
                  phase_ff  <= P_PROD;
               end
            end
            P_PROD: begin
               mcand_ff  <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
               acc_ff    <= acc_in;
               cnt_ff    <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  rem_ff   <= {1'b0, sq_ff, {lwc_pkg::SCALE_SH{1'b0}}};
                  dvs_ff   <= {1'b0, acc_in, {lwc_pkg::SCALE_SH{1'b0}}};
                  quo_ff   <= '0;
                  cnt_ff   <= CW'(QW - 1);
                  phase_ff <= P_DIV;
               end
            end
            P_DIV: begin
               if (dvs_ff <= rem_ff) begin
                  rem_ff <= rem_ff - dvs_ff;
                  quo_ff <= {quo_ff[QW-2:0], 1'b1};
               end else begin
                  quo_ff <= {quo_ff[QW-2:0], 1'b0};
               end
               dvs_ff <= dvs_ff >> 1;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  root_ff  <= '0;
                  cnt_ff   <= CW'(RT - 1);
                  phase_ff <= P_ROOT;
               end
            end
            P_ROOT: begin
               if (trial_sq <= (2*RT)'(quo_ff)) begin
                  root_ff <= trial;
               end
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  phase_ff <= P_DONE;
               end
            end
            P_DONE: begin
               if (ack) begin
                  phase_ff <= P_IDLE;
               end
            end
            default: begin
               phase_ff <= P_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### design/lwc_back.sv
`default_nettype none

module lwc_back #(
   parameter int EW = 44
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          empty,
   input  wire logic [6*EW-1:0]               rdata,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [lwc_pkg::CORR_W-1:0]         rsp_corr_re,
   output logic [lwc_pkg::CORR_W-1:0]         rsp_corr_im,
   output logic                               rsp_re_degenerate,
   output logic                               rsp_im_degenerate
);

   lwc_pkg::lwc_status_type      re_status, im_status;
   logic [lwc_pkg::CORR_W-1:0]   re_corr, im_corr;
   logic                         re_degen, im_degen;
   logic                         rsp_valid_ff;
   logic [lwc_pkg::CORR_W-1:0]   corr_re_ff, corr_im_ff;
   logic                         degen_re_ff, degen_im_ff;
   logic                         load;

   assign pop  = !re_status.busy && !empty;
   assign load = re_status.done && im_status.done && (!rsp_valid_ff || !rsp_stall);

   lwc_ratio #(.EW(EW)) u_re (
      .clock  (clock),
      .reset  (reset),
      .start  (pop),
      .ack    (load),
      .num    (rdata[6*EW-1:5*EW]),
      .da     (rdata[5*EW-1:4*EW]),
      .db     (rdata[4*EW-1:3*EW]),
      .status (re_status),
      .corr   (re_corr),
      .degen  (re_degen)
   );

   lwc_ratio #(.EW(EW)) u_im (
      .clock  (clock),
      .reset  (reset),
      .start  (pop),
      .ack    (load),
      .num    (rdata[3*EW-1:2*EW]),
      .da     (rdata[2*EW-1:EW]),
      .db     (rdata[EW-1:0]),
      .status (im_status),
      .corr   (im_corr),
      .degen  (im_degen)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         corr_re_ff  <= re_corr;
         corr_im_ff  <= im_corr;
         degen_re_ff <= re_degen;
         degen_im_ff <= im_degen;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_corr_re       = corr_re_ff;
   assign rsp_corr_im       = corr_im_ff;
   assign rsp_re_degenerate = degen_re_ff;
   assign rsp_im_degenerate = degen_im_ff;

endmodule

`default_nettype wire

### design/lagged_window_correlator_core.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_sample_re, req_sample_im
// rsp       out        rsp_valid/rsp_stall  rsp_corr_re, rsp_corr_im, rsp_*_degenerate
//
// The front takes a sample only when idle, runs product and accumulate steps, and
// normalize and push once the history is full; push waits while the queue is full.
// Both serial multiply, divide and root units take a queue entry only when idle
// and set the sustained rate; EW = 2*SAMPLE_BITS + 2*clog2(WINDOW_LEN+1) + 2.
// Reset is synchronous and clears the history, window sums and all control state.
// A two-entry queue and the output register let either side stall independently.
`default_nettype none

module lagged_window_correlator_core #(
   parameter int WINDOW_LEN  = 16,
   parameter int LAG_LEN     = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [lwc_pkg::FIELD_W-1:0]   req_sample_re,
   input  wire logic [lwc_pkg::FIELD_W-1:0]   req_sample_im,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [lwc_pkg::CORR_W-1:0]         rsp_corr_re,
   output logic [lwc_pkg::CORR_W-1:0]         rsp_corr_im,
   output logic                               rsp_re_degenerate,
   output logic                               rsp_im_degenerate
);

   localparam int EW = 2 * SAMPLE_BITS + 2 * $clog2(WINDOW_LEN + 1) + 2;

   logic              push, pop, full, empty;
   logic [6*EW-1:0]   wdata, rdata;

   lwc_front #(
      .WINDOW_LEN  (WINDOW_LEN),
      .LAG_LEN     (LAG_LEN),
      .SAMPLE_BITS (SAMPLE_BITS),
      .EW          (EW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_re (req_sample_re),
      .req_sample_im (req_sample_im),
      .push          (push),
      .full          (full),
      .wdata         (wdata)
   );

   lwc_queue #(.DATA_W(6 * EW)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (wdata),
      .pop   (pop),
      .rdata (rdata),
      .full  (full),
      .empty (empty)
   );

   lwc_back #(.EW(EW)) u_back (
      .clock             (clock),
      .reset             (reset),
      .empty             (empty),
      .rdata             (rdata),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_corr_re       (rsp_corr_re),
      .rsp_corr_im       (rsp_corr_im),
      .rsp_re_degenerate (rsp_re_degenerate),
      .rsp_im_degenerate (rsp_im_degenerate)
   );

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench;

   localparam int WIN   = 16;
   localparam int LAG   = 64;
   localparam int HIST  = LAG + WIN;
   localparam int ONE   = lwc_pkg::ONE_Q14;
   localparam int FW    = lwc_pkg::FIELD_W;
   localparam int CW    = lwc_pkg::CORR_W;

   localparam int PH_NONE     = 0;
   localparam int PH_SEND     = 1;
   localparam int PH_RECV     = 2;
   localparam int PH_BOTH     = 3;
   localparam int PH_PRESSURE = 4;

   localparam int PAT_CONST = 0;
   localparam int PAT_ALT   = 1;
   localparam int PAT_RAND  = 2;

   typedef struct packed {
      logic [CW-1:0] re;
      logic [CW-1:0] im;
      logic          re_dg;
      logic          im_dg;
   } corr_type;

   typedef struct {
      int            pat;
      logic [FW-1:0] re;
      logic [FW-1:0] im;
      int            count;
      logic          typed;
      corr_type      want;
   } row_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic [FW-1:0] req_sample_re;
   logic [FW-1:0] req_sample_im;
   logic          rsp_valid;
   logic          rsp_stall;
   logic [CW-1:0] rsp_corr_re;
   logic [CW-1:0] rsp_corr_im;
   logic          rsp_re_degenerate;
   logic          rsp_im_degenerate;

   lagged_window_correlator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_sample_re(req_sample_re), .req_sample_im(req_sample_im),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_corr_re(rsp_corr_re), .rsp_corr_im(rsp_corr_im),
      .rsp_re_degenerate(rsp_re_degenerate), .rsp_im_degenerate(rsp_im_degenerate)
   );

   int       errors = 0;
   int       phase  = PH_NONE;
   corr_type coeff_q[$];

   longint hist_re[HIST];
   longint hist_im[HIST];
   int     head = 0;
   int     fill = 0;
   longint re_se = 0, re_sl = 0, re_sx = 0, re_qe = 0, re_ql = 0;
   longint im_se = 0, im_sl = 0, im_sx = 0, im_qe = 0, im_ql = 0;

   initial clock = 0;
   always #1 clock = ~clock;

   function automatic void pearson(input longint se, input longint sl, input longint sx,
                                   input longint qe, input longint ql,
                                   output logic [CW-1:0] c, output logic dg);
      longint        n, da, db;
      logic [159:0]  prod, rhs, lhs, t, m;
      int            lo, hi, mid;
      n  = WIN * sx - se * sl;
      da = WIN * qe - se * se;
      db = WIN * ql - sl * sl;
      if (da <= 0 || db <= 0) begin
         c  = '0;
         dg = 1'b1;
         return;
      end
      dg   = 1'b0;
      m    = (n < 0) ? 160'(-n) : 160'(n);
      prod = 160'(da) * 160'(db);
      rhs  = (m * m) << lwc_pkg::SCALE_SH;
      lo   = 0;
      hi   = ONE;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t   = 160'(2 * mid - 1);
         lhs = prod * t * t;
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      c = (n < 0) ? CW'(-lo) : CW'(lo);
   endfunction

   function automatic void roll(ref longint se, ref longint sl, ref longint sx,
                                ref longint qe, ref longint ql,
                                input longint xn, input longint xg,
                                input longint xl, input longint xo);
      sl += xn - xl;
      ql += xn * xn - xl * xl;
      se += xg - xo;
      qe += xg * xg - xo * xo;
      sx += xg * xn - xo * xl;
   endfunction

   function automatic bit predict_coeff(input logic [FW-1:0] sre, input logic [FW-1:0] sim,
                                        output corr_type r);
      longint vr, vi;
      int     ig, il;
      vr = longint'($signed(sre));
      vi = longint'($signed(sim));
      ig = (head + HIST - LAG) % HIST;
      il = (head + HIST - WIN) % HIST;
      roll(re_se, re_sl, re_sx, re_qe, re_ql, vr, hist_re[ig], hist_re[il], hist_re[head]);
      roll(im_se, im_sl, im_sx, im_qe, im_ql, vi, hist_im[ig], hist_im[il], hist_im[head]);
      hist_re[head] = vr;
      hist_im[head] = vi;
      head = (head + 1) % HIST;
      if (fill < HIST) fill++;
      if (fill < HIST) return 0;
      pearson(re_se, re_sl, re_sx, re_qe, re_ql, r.re, r.re_dg);
      pearson(im_se, im_sl, im_sx, im_qe, im_ql, r.im, r.im_dg);
      return 1;
   endfunction

   task automatic transfer(input logic [FW-1:0] sre, input logic [FW-1:0] sim,
                           input logic typed, input corr_type want);
      int       idle;
      corr_type r;
      idle = (phase == PH_SEND) ? 46 : (phase == PH_BOTH) ? 10 : 0;
      while ($urandom_range(99) < idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_re <= sre;
      req_sample_im <= sim;
      do @(posedge clock); while (req_stall);
      if (predict_coeff(sre, sim, r)) begin
         if (typed && r != want) begin
            errors++;
            $display("%0t predictor disagrees with table: exp %h %h %b %b got %h %h %b %b",
                     $time, want.re, want.im, want.re_dg, want.im_dg,
                     r.re, r.im, r.re_dg, r.im_dg);
         end
         coeff_q.push_back(typed ? want : r);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (coeff_q.size() == 0) begin
            errors++;
            $display("%0t unexpected transfer: exp none got %h %h %b %b", $time,
                     rsp_corr_re, rsp_corr_im, rsp_re_degenerate, rsp_im_degenerate);
         end else begin
            if (rsp_corr_re !== coeff_q[0].re) begin
               errors++;
               $display("%0t corr_re: exp %h got %h", $time, coeff_q[0].re, rsp_corr_re);
            end
            if (rsp_corr_im !== coeff_q[0].im) begin
               errors++;
               $display("%0t corr_im: exp %h got %h", $time, coeff_q[0].im, rsp_corr_im);
            end
            if (rsp_re_degenerate !== coeff_q[0].re_dg) begin
               errors++;
               $display("%0t re_degenerate: exp %b got %b", $time,
                        coeff_q[0].re_dg, rsp_re_degenerate);
            end
            if (rsp_im_degenerate !== coeff_q[0].im_dg) begin
               errors++;
               $display("%0t im_degenerate: exp %b got %b", $time,
                        coeff_q[0].im_dg, rsp_im_degenerate);
            end
            void'(coeff_q.pop_front());
         end
      end
   end

   initial begin
      int  hold;
      bit  held;
      int  pct;
      hold      = 0;
      held      = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase == PH_PRESSURE && !held) begin
            held = 1;
            hold = 3000;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else begin
            pct = (phase == PH_RECV) ? 46 : (phase == PH_BOTH) ? 10 : 0;
            rsp_stall <= ($urandom_range(99) < pct);
         end
      end
   end

   initial begin
      #20000000;
      $display("status: fail");
      $finish;
   end

   initial begin
      row_type       rows[$];
      corr_type      none;
      corr_type      dgn;
      logic [FW-1:0] a, b, sa, sb;
      logic [FW-1:0] per_re[8];
      logic [FW-1:0] per_im[8];
      int            kind, lim, k;
      none = '{re: '0, im: '0, re_dg: 1'b0, im_dg: 1'b0};
      dgn  = '{re: '0, im: '0, re_dg: 1'b1, im_dg: 1'b1};
      foreach (hist_re[i]) begin
         hist_re[i] = 0;
         hist_im[i] = 0;
      end
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_sample_re <= '0;
      req_sample_im <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      rows = '{
         '{PAT_CONST, 16'h0000, 16'h0000, 80, 1'b1, dgn},
         '{PAT_CONST, 16'h7fff, 16'h8000, 16, 1'b0, none},
         '{PAT_CONST, 16'h8000, 16'h7fff, 16, 1'b1, dgn},
         '{PAT_ALT,   16'h7fff, 16'h8000, 96, 1'b0, none},
         '{PAT_RAND,  16'h0000, 16'h0000, 40, 1'b0, none},
         '{PAT_CONST, 16'hffff, 16'h0001, 16, 1'b1, dgn},
         '{PAT_ALT,   16'h8000, 16'h0001, 40, 1'b0, none},
         '{PAT_CONST, 16'h0001, 16'hffff, 16, 1'b1, dgn}
      };
      foreach (rows[r]) begin
         for (int i = 0; i < rows[r].count; i++) begin
            case (rows[r].pat)
               PAT_CONST: begin
                  a = rows[r].re;
                  b = rows[r].im;
               end
               PAT_ALT: begin
                  a = i[0] ? -rows[r].re : rows[r].re;
                  b = i[0] ? -rows[r].im : rows[r].im;
               end
               default: begin
                  a = FW'($urandom);
                  b = FW'($urandom);
               end
            endcase
            transfer(a, b, rows[r].typed && i == rows[r].count - 1, rows[r].want);
         end
      end

      for (int n = 0; n < 280; n += 40) begin
         phase = (n / 40) % 5;
         kind = $urandom_range(9);
         lim  = $urandom_range(1, 32767);
         sa   = FW'($urandom);
         sb   = FW'($urandom);
         for (int j = 0; j < 8; j++) begin
            per_re[j] = FW'($urandom);
            per_im[j] = FW'($urandom);
         end
         for (int i = 0; i < 40; i++) begin
            k = i % 8;
            case (kind)
               0, 1, 2, 3: begin
                  a = FW'($urandom);
                  b = FW'($urandom);
               end
               4: begin
                  a = FW'($urandom_range(0, 16) - 8);
                  b = FW'($urandom_range(0, 2 * lim) - lim);
               end
               5: begin
                  a = sa;
                  b = sb;
               end
               6: begin
                  a = sa;
                  b = FW'($urandom);
               end
               7: begin
                  a = FW'($urandom);
                  b = sb;
               end
               default: begin
                  a = ($urandom_range(9) == 0) ? FW'($urandom) : per_re[k];
                  b = per_im[k];
               end
            endcase
            transfer(a, b, 1'b0, none);
         end
      end

      req_valid <= 1'b0;
      phase      = PH_NONE;
      while (coeff_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
